/* sv/ffsa_pkg.sv */
// ffsa_pkg: shared types and codes for the first-fit slot allocator
// no dependencies; imported by every allocator module

package ffsa_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIT,
        ST_APPLY,
        ST_FINISH
    } ffsa_state_t;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef struct packed {
        logic start;
        logic step;
    } scan_ctl_t;

endpackage

/* sv/first_fit_slot_allocator.sv */
// first_fit_slot_allocator: top level, occupancy shift register and sequencer
// depends on ffsa_pkg, ffsa_fit_scan, ffsa_stat_scan
//
//  channel   handshake             fields
//  request   in_valid / in_ready   opcode, run_start, run_length
//  result    out_valid / out_ready status, alloc_start, free_count, longest_run
//
// the map rotates one slot per cycle through the scanners during each pass
// allocate with a legal length: a first-fit search pass over the map, then
// an update and statistics pass, then the result is loaded
// other requests skip the search pass
// a new request is taken once the result is loaded, even while it waits
// reset empties the map; a stalled result holds the sequencer before loading

module first_fit_slot_allocator #(
    parameter int SLOTS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [3:0] run_start,
    input  logic [4:0] run_length,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       status,
    output logic [3:0] alloc_start,
    output logic [4:0] free_count,
    output logic [4:0] longest_run
);
    import ffsa_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int WW = (CW > 5) ? CW : 5;
    localparam int EW = WW + 1;

    ffsa_state_t    state_reg, state_next;
    logic [SLOTS-1:0] map_reg, map_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [1:0]     op_reg, op_next;
    logic [CW-1:0]  len_reg, len_next;
    logic           ok_reg, ok_next;
    logic [EW-1:0]  lo_reg, lo_next;
    logic [EW-1:0]  hi_reg, hi_next;

    logic           out_valid_reg;
    logic           status_reg;
    logic [3:0]     alloc_start_reg;
    logic [4:0]     free_count_reg;
    logic [4:0]     longest_run_reg;

    logic           accept;
    logic           last_slot;
    logic           out_free;
    logic           len_legal;
    logic           free_legal;
    logic [EW-1:0]  len_ext;
    logic [EW-1:0]  free_end;
    logic           in_rng;
    logic           new_bit;
    logic           shift_fit;
    logic           shift_apply;
    logic           load_out;

    scan_ctl_t      fit_ctl;
    scan_ctl_t      stat_ctl;
    logic           fit_found;
    logic [IW-1:0]  fit_start;
    logic [CW-1:0]  free_cnt;
    logic [CW-1:0]  best_run;

    assign accept     = in_valid && in_ready;
    assign last_slot  = (idx_reg == IW'(SLOTS - 1));
    assign out_free   = !out_valid_reg || out_ready;
    assign len_ext    = EW'(run_length);
    assign free_end   = EW'(run_start) + len_ext;
    assign len_legal  = (run_length != 5'd0) && (len_ext <= EW'(SLOTS));
    assign free_legal = (free_end <= EW'(SLOTS));

    assign in_rng  = (EW'(idx_reg) >= lo_reg) && (EW'(idx_reg) < hi_reg);
    always_comb
    begin
        if (op_reg == OP_CLEAR)
        begin
            new_bit = 1'b0;
        end
        else if (ok_reg && in_rng)
        begin
            new_bit = (op_reg == OP_ALLOC);
        end
        else
        begin
            new_bit = map_reg[0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ((opcode == OP_ALLOC) && len_legal) ? ST_FIT : ST_APPLY;
                end
            end
            ST_FIT:
            begin
                if (last_slot)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (last_slot)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready       = 1'b0;
        fit_ctl        = '0;
        stat_ctl       = '0;
        shift_fit      = 1'b0;
        shift_apply    = 1'b0;
        load_out       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                fit_ctl.start  = in_valid;
                stat_ctl.start = in_valid;
            end
            ST_FIT:
            begin
                fit_ctl.step = 1'b1;
                shift_fit    = 1'b1;
            end
            ST_APPLY:
            begin
                stat_ctl.step = 1'b1;
                shift_apply   = 1'b1;
            end
            ST_FINISH:
            begin
                load_out = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // request registers and map
    always_comb
    begin
        map_next = map_reg;
        idx_next = idx_reg;
        op_next  = op_reg;
        len_next = len_reg;
        ok_next  = ok_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        if (accept)
        begin
            idx_next = '0;
            op_next  = opcode;
            len_next = CW'(run_length);
            lo_next  = EW'(run_start);
            hi_next  = free_end;
            case (opcode)
                OP_ALLOC: ok_next = 1'b0;
                OP_FREE:  ok_next = free_legal;
                OP_CLEAR: ok_next = 1'b1;
                default:  ok_next = 1'b0;
            endcase
        end
        if (shift_fit)
        begin
            map_next = {map_reg[0], map_reg[SLOTS-1:1]};
            idx_next = last_slot ? '0 : idx_reg + IW'(1);
        end
        if (shift_fit && last_slot)
        begin
            ok_next = fit_found;
            lo_next = EW'(fit_start);
            hi_next = EW'(fit_start) + EW'(len_reg);
        end
        if (shift_apply)
        begin
            map_next = {new_bit, map_reg[SLOTS-1:1]};
            idx_next = last_slot ? '0 : idx_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            map_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            map_reg   <= map_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        len_reg <= len_next;
        ok_reg  <= ok_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg      <= ok_reg ? STATUS_DONE : STATUS_REFUSED;
            alloc_start_reg <= ((op_reg == OP_ALLOC) && ok_reg) ? 4'(lo_reg) : 4'd0;
            free_count_reg  <= 5'(free_cnt);
            longest_run_reg <= 5'(best_run);
        end
    end

    ffsa_fit_scan #(
        .SLOTS(SLOTS)
    ) u_fit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (fit_ctl),
        .bit_used  (map_reg[0]),
        .idx       (idx_reg),
        .len       (len_reg),
        .found     (fit_found),
        .fit_start (fit_start)
    );

    ffsa_stat_scan #(
        .SLOTS(SLOTS)
    ) u_stat (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (stat_ctl),
        .bit_used (new_bit),
        .free_cnt (free_cnt),
        .best_run (best_run)
    );

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign alloc_start = alloc_start_reg;
    assign free_count  = free_count_reg;
    assign longest_run = longest_run_reg;

endmodule

/* sv/ffsa_fit_scan.sv */
// ffsa_fit_scan: bit-serial first-fit search over the rotating occupancy map
// depends on ffsa_pkg

module ffsa_fit_scan #(
    parameter int SLOTS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ffsa_pkg::scan_ctl_t          ctl,
    input  logic                         bit_used,
    input  logic [$clog2(SLOTS)-1:0]     idx,
    input  logic [$clog2(SLOTS+1)-1:0]   len,
    output logic                         found,
    output logic [$clog2(SLOTS)-1:0]     fit_start
);
    import ffsa_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [CW-1:0] run_reg, run_next;
    logic          found_reg, found_next;
    logic [IW-1:0] start_reg, start_next;
    logic [CW-1:0] run_step;

    assign run_step = bit_used ? '0 : run_reg + CW'(1);

    always_comb
    begin
        run_next   = run_reg;
        found_next = found_reg;
        start_next = start_reg;
        if (ctl.start)
        begin
            run_next   = '0;
            found_next = 1'b0;
            start_next = '0;
        end
        else if (ctl.step)
        begin
            run_next = run_step;
            if (!found_reg && (run_step == len))
            begin
                found_next = 1'b1;
                start_next = IW'(CW'(idx) + CW'(1) - len);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= '0;
            found_reg <= 1'b0;
            start_reg <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            found_reg <= found_next;
            start_reg <= start_next;
        end
    end

    // includes the slot being stepped, so a fit ending at the last slot counts
    assign found     = found_next;
    assign fit_start = start_next;

endmodule

/* sv/ffsa_stat_scan.sv */
// ffsa_stat_scan: bit-serial free count and longest free run
// depends on ffsa_pkg

module ffsa_stat_scan #(
    parameter int SLOTS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ffsa_pkg::scan_ctl_t          ctl,
    input  logic                         bit_used,
    output logic [$clog2(SLOTS+1)-1:0]   free_cnt,
    output logic [$clog2(SLOTS+1)-1:0]   best_run
);
    import ffsa_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] run_reg, run_next;
    logic [CW-1:0] best_reg, best_next;
    logic [CW-1:0] run_step;

    assign run_step = bit_used ? '0 : run_reg + CW'(1);

    always_comb
    begin
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        best_next = best_reg;
        if (ctl.start)
        begin
            cnt_next  = '0;
            run_next  = '0;
            best_next = '0;
        end
        else if (ctl.step)
        begin
            cnt_next = bit_used ? cnt_reg : cnt_reg + CW'(1);
            run_next = run_step;
            if (run_step > best_reg)
            begin
                best_next = run_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= '0;
            best_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            best_reg <= best_next;
        end
    end

    assign free_cnt = cnt_reg;
    assign best_run = best_reg;

endmodule

/* sv/ffsa_check.sv */
// ffsa_check: port-level checks for the first-fit slot allocator
// depends on first_fit_slot_allocator; bound to it below

module ffsa_check (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       status,
    input logic [3:0] alloc_start,
    input logic [4:0] free_count,
    input logic [4:0] longest_run
);

    // a held result beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(alloc_start) && $stable(free_count) && $stable(longest_run))
    else $error("result beat changed while stalled");

    // one request at a time: no back-to-back request beats
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

    // refused beats carry no start slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> alloc_start == 4'd0)
    else $error("refused beat with nonzero start");

    // longest free run never exceeds free slots
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> longest_run <= free_count)
    else $error("longest run above free count");

endmodule

bind first_fit_slot_allocator ffsa_check u_ffsa_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .alloc_start (alloc_start),
    .free_count  (free_count),
    .longest_run (longest_run)
);
